// ===== hdl/bsim_pkg.sv =====
// Package for the bank switch IRQ mapper: codes, decoded addresses and the
// structs that pass between the mapper core and the top level. No dependencies.
`default_nettype none
package bsim_pkg;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Kinds of update carried by a result transaction.
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_PROGRAM = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;
   localparam logic [1:0] KIND_MIRROR  = 2'd3;

   // Mirroring codes.
   localparam logic [1:0] MIRR_HORIZONTAL = 2'd0;
   localparam logic [1:0] MIRR_SINGLE_LOW = 2'd2;

   // Decoded addresses and pages of IRQ timer, mirroring and bank registers.
   localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hF000;
   localparam logic [15:0] ADDR_IRQ_CONTROL = 16'hF001;
   localparam logic [15:0] ADDR_MIRRORING   = 16'hF002;
   localparam logic [3:0]  PAGE_IRQ_LATCH   = 4'hE;
   localparam logic [3:0]  PAGE_PROG_LOW    = 4'h8;
   localparam logic [3:0]  PAGE_PROG_HIGH   = 4'h9;
   localparam logic [3:0]  PAGE_PATTERN_LO  = 4'hA;
   localparam logic [3:0]  PAGE_PATTERN_HI  = 4'hD;

   // Timer reset value and the masks for the bit-change IRQ modes.
   localparam logic [15:0] IRQ_RESET_VALUE = 16'hFFFF;
   localparam logic [15:0] MASK_TOP4       = 16'hF000;
   localparam logic [15:0] MASK_TOP8       = 16'hFF00;
   localparam logic [15:0] MASK_TOP12      = 16'hFFF0;

   // Mode codes of the IRQ timer.
   localparam logic [2:0] MODE_UNDERFLOW = 3'd0;
   localparam logic [2:0] MODE_TOP4      = 3'd1;
   localparam logic [2:0] MODE_TOP8_A    = 3'd2;
   localparam logic [2:0] MODE_TOP8_B    = 3'd3;

   // Bank register file geometry.
   localparam int BANK_COUNT = 11;
   localparam int PROG_COUNT = 3;

   // Register indexes of the configuration port.
   localparam logic REG_PROGRAM_SIZE = 1'b0;

   // One input transaction.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  cycles;
   } bsim_item_type;

   // Results caused by one input transaction, queued as one entry.
   // A restart entry expands into four program window results.
   typedef struct packed {
      logic       restart;
      logic [1:0] kind;
      logic [2:0] slot;
      logic [7:0] bank;
      logic [7:0] bank_b;
      logic [1:0] mirr;
      logic       irq;
   } bsim_entry_type;

endpackage
`default_nettype wire

// ===== hdl/bsim_req_if.sv =====
// Input channel interface of the bank switch IRQ mapper: valid, ready and
// the fields of one input transaction. No dependencies.
`default_nettype none
interface bsim_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [7:0]  cycles;

   modport source (output valid, opcode, address, write_data, cycles, input ready);
   modport sink (input valid, opcode, address, write_data, cycles, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsim_rsp_if.sv =====
// Result channel interface of the bank switch IRQ mapper: valid, ready and
// the fields of one result transaction. No dependencies.
`default_nettype none
interface bsim_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] update_kind;
   logic [2:0] slot;
   logic [7:0] bank_number;
   logic [1:0] mirroring;
   logic       irq_line;
   logic       last;

   modport source (output valid, update_kind, slot, bank_number, mirroring, irq_line, last,
                   input ready);
   modport sink (input valid, update_kind, slot, bank_number, mirroring, irq_line, last,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/bsim_core.sv =====
// Mapper core: bank registers, IRQ latch and counter, and the decode of one
// input transaction into a result entry. Depends on bsim_pkg.
`default_nettype none
module bsim_core #(
   parameter int TICK_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      accept,
   input  bsim_pkg::bsim_item_type  item,
   input  wire [8:0]                program_size,
   output bsim_pkg::bsim_entry_type entry
);
   import bsim_pkg::*;

   // Only the low TICK_BITS bits of the cycle count take part, at most all eight.
   localparam int TickUse = (TICK_BITS < 8) ? TICK_BITS : 8;
   localparam logic [7:0] TickMask = 8'((1 << TickUse) - 1);

   logic [7:0]  bank_ff [BANK_COUNT];
   logic [7:0]  bank_in [BANK_COUNT];
   logic [15:0] latch_ff, latch_in;
   logic [15:0] count_ff, count_in;
   logic [2:0]  mode_ff, mode_in;
   logic        enabled_ff, enabled_in;
   logic        active_ff, active_in;

   logic [3:0]  page;
   logic [11:0] low;
   logic [3:0]  nib;
   logic        bank_hit;
   logic [3:0]  bank_idx;
   logic [3:0]  page_off;
   logic [7:0]  bank_cur;
   logic [7:0]  bank_new;
   logic [15:0] tick_cyc;
   logic [15:0] tick_now;
   logic [15:0] tick_mask;
   logic        tick_fire;
   logic [7:0]  size_m1;
   logic [7:0]  size_m2;

   // Address decode and the nibble update of the addressed bank register.
   assign page     = item.address[15:12];
   assign low      = item.address[11:0];
   assign nib      = item.write_data[3:0];
   assign bank_hit = (page >= PAGE_PROG_LOW) && (page <= PAGE_PATTERN_HI) && (low <= 12'd3)
                     && !((page == PAGE_PROG_HIGH) && (low > 12'd1));
   assign page_off = page - PAGE_PROG_LOW;
   assign bank_idx = {page_off[2:0], low[1]} - ((page >= PAGE_PATTERN_LO) ? 4'd1 : 4'd0);
   assign bank_cur = bank_ff[bank_idx];
   assign bank_new = low[0] ? {nib, bank_cur[3:0]} : {bank_cur[7:4], nib};

   // Timer subtract and the fire test of the selected mode.
   assign tick_cyc = {8'd0, item.cycles & TickMask};
   assign tick_now = count_ff - tick_cyc;

   always_comb begin
      case (mode_ff)
         MODE_TOP4:   tick_mask = MASK_TOP4;
         MODE_TOP8_A: tick_mask = MASK_TOP8;
         MODE_TOP8_B: tick_mask = MASK_TOP8;
         default:     tick_mask = MASK_TOP12;
      endcase
      if (mode_ff == MODE_UNDERFLOW) begin
         tick_fire = tick_cyc >= count_ff;
      end else begin
         tick_fire = (tick_cyc > count_ff) || ((tick_now & tick_mask) != (count_ff & tick_mask));
      end
   end

   assign size_m1 = 8'(program_size - 9'd1);
   assign size_m2 = 8'(program_size - 9'd2);

   // Next state and the result entry of the transaction at the input.
   always_comb begin
      bank_in    = bank_ff;
      latch_in   = latch_ff;
      count_in   = count_ff;
      mode_in    = mode_ff;
      enabled_in = enabled_ff;
      active_in  = active_ff;
      entry      = '0;
      entry.kind = KIND_NONE;
      case (item.opcode)
         OP_WRITE: begin
            if (bank_hit) begin
               bank_in[bank_idx] = bank_new;
               entry.bank = bank_new;
               if (bank_idx < 4'(PROG_COUNT)) begin
                  entry.kind = KIND_PROGRAM;
                  entry.slot = bank_idx[2:0];
               end else begin
                  entry.kind = KIND_PATTERN;
                  entry.slot = 3'(bank_idx - 4'(PROG_COUNT));
               end
            end else if ((page == PAGE_IRQ_LATCH) && (low <= 12'd3)) begin
               latch_in[{low[1:0], 2'b00} +: 4] = nib;
            end else if (item.address == ADDR_IRQ_RELOAD) begin
               count_in = latch_ff;
            end else if (item.address == ADDR_IRQ_CONTROL) begin
               mode_in    = item.write_data[3:1];
               enabled_in = item.write_data[0];
               active_in  = 1'b0;
            end else if (item.address == ADDR_MIRRORING) begin
               entry.kind = KIND_MIRROR;
               entry.mirr = (item.write_data[1:0] > MIRR_SINGLE_LOW) ? MIRR_SINGLE_LOW
                                                                     : item.write_data[1:0];
            end
         end
         OP_TICK: begin
            if (enabled_ff && (count_ff != 16'd0)) begin
               if (tick_fire) begin
                  count_in   = 16'd0;
                  enabled_in = 1'b0;
                  active_in  = 1'b1;
               end else begin
                  count_in = tick_now;
               end
            end
         end
         OP_RESTART: begin
            for (int i = 0; i < BANK_COUNT; i++) begin
               bank_in[i] = 8'd0;
            end
            bank_in[2]    = size_m2;
            bank_in[3]    = size_m1;
            latch_in      = IRQ_RESET_VALUE;
            count_in      = IRQ_RESET_VALUE;
            mode_in       = MODE_UNDERFLOW;
            enabled_in    = 1'b0;
            active_in     = 1'b0;
            entry.restart = 1'b1;
            entry.kind    = KIND_PROGRAM;
            entry.bank    = size_m2;
            entry.bank_b  = size_m1;
         end
         default: begin
         end
      endcase
      entry.irq = active_in;
   end

   // Outside reset, state registers change only when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_COUNT; i++) begin
            bank_ff[i] <= 8'd0;
         end
         latch_ff   <= IRQ_RESET_VALUE;
         count_ff   <= IRQ_RESET_VALUE;
         mode_ff    <= MODE_UNDERFLOW;
         enabled_ff <= 1'b0;
         active_ff  <= 1'b0;
      end else if (accept) begin
         bank_ff    <= bank_in;
         latch_ff   <= latch_in;
         count_ff   <= count_in;
         mode_ff    <= mode_in;
         enabled_ff <= enabled_in;
         active_ff  <= active_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bank_switch_irq_mapper_unit.sv =====
// Top level of the bank switch IRQ mapper: request and result channels,
// APB-style register port and the result queue. Depends on bsim_pkg,
// bsim_req_if, bsim_rsp_if and bsim_core.
//
// Usage:
//   The req channel carries bus writes, IRQ timer ticks and
//   restarts. Each accepted transaction updates the mapper state at the
//   edge that accepts it, and its results enter a two-entry queue.
//   A bus write, tick or ignored opcode gives one result; a restart gives
//   four program window results, one per cycle unless rsp stalls; last
//   marks the final one. Results reach rsp from the registered queue. A
//   transaction can be accepted every cycle while the queue is not full;
//   sustained throughput is one result per cycle unless rsp stalls.
//   The queue keeps taking transactions while a result waits to be taken,
//   and req.ready drops only when both queue entries are occupied.
//   The csr port holds program_size_banks at byte address 0 (reset 16).
//   Reset clears the queue and returns every mapper register to its reset
//   value; it takes effect at the first clock edge with reset high.
`default_nettype none
module bank_switch_irq_mapper_unit #(
   parameter int TICK_BITS = 8
) (
   input  wire         clock,
   input  wire         reset,
   bsim_req_if.sink    req,
   bsim_rsp_if.source  rsp,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bsim_pkg::*;

   logic [8:0]     size_ff;
   bsim_item_type  item;
   bsim_entry_type entry;
   bsim_entry_type queue_ff [2];
   bsim_entry_type head;
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     count_ff;
   logic [1:0]     sub_ff;
   logic           push;
   logic           pop;
   logic           rsp_last;

   // Configuration register port; a write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PROGRAM_SIZE) ? {23'd0, size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 9'd16;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_PROGRAM_SIZE)) begin
         size_ff <= csr_pwdata[8:0];
      end
   end

   // Mapper core works on the transaction at the input.
   assign item.opcode     = req.opcode;
   assign item.address    = req.address;
   assign item.write_data = req.write_data;
   assign item.cycles     = req.cycles;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;

   bsim_core #(
      .TICK_BITS (TICK_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (push),
      .item         (item),
      .program_size (size_ff),
      .entry        (entry)
   );

   // Result queue; a restart entry is played out as four results.
   assign head     = queue_ff[rd_ptr_ff];
   assign rsp_last = !head.restart || (sub_ff == 2'd3);
   assign pop      = rsp.valid && rsp.ready && rsp_last;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sub_ff    <= 2'd0;
         end else if (rsp.valid && rsp.ready) begin
            sub_ff <= sub_ff + 2'd1;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Result fields of the current transaction.
   always_comb begin
      rsp.valid       = (count_ff != 2'd0);
      rsp.update_kind = head.kind;
      rsp.mirroring   = head.mirr;
      rsp.irq_line    = head.irq;
      rsp.last        = rsp_last;
      if (head.restart) begin
         rsp.slot = {1'b0, sub_ff};
         case (sub_ff)
            2'd0:    rsp.bank_number = 8'd0;
            2'd1:    rsp.bank_number = 8'd1;
            2'd2:    rsp.bank_number = head.bank;
            default: rsp.bank_number = head.bank_b;
         endcase
      end else begin
         rsp.slot        = head.slot;
         rsp.bank_number = head.bank;
      end
   end

   // The queue never holds more than two entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("result queue overflow");

   // Only a restart entry at the head plays out more than one result.
   assert property (@(posedge clock) disable iff (reset)
                    (sub_ff != 2'd0) |-> (head.restart && (count_ff != 2'd0)))
      else $error("result index advanced on a single-result entry");

   // A final result taken without a new transaction frees one entry.
   assert property (@(posedge clock) disable iff (reset)
                    (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue occupancy did not drop after a final result");

   // A stalled multi-result entry keeps its position.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp.valid && !rsp.ready) |=> (sub_ff == $past(sub_ff)))
      else $error("result index moved while the receiver stalled");

endmodule
`default_nettype wire
